>>> rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/fbfa_pkg.sv
// Shared types and constants for the first/best fit block allocator.
// No dependencies; imported by every allocator module.
`timescale 1ns / 1ps

package fbfa_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int VAL_W          = 16;
	localparam int BIDX_W         = 4;
	localparam int NB_W           = 5;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 5;
	localparam logic [NB_W-1:0] NUM_BLOCKS_RST = NB_W'(16);

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 2'd1;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

	localparam logic FIT_FIRST = 1'b0;
	localparam logic FIT_BEST  = 1'b1;

	typedef struct packed {
		logic              action;
		logic [BIDX_W-1:0] block_index;
		logic [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic              granted;
		logic [BIDX_W-1:0] chosen_block;
		logic [VAL_W-1:0]  free_before;
		logic [VAL_W-1:0]  free_after;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic finish;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/fbfa_ctrl.sv
// Controller state machine for the block allocator.
// Depends on fbfa_pkg and assert_macros.svh; drives the datapath commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbfa_ctrl
	import fbfa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_action,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_action == ACT_ALLOC) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result register must be empty or draining this cycle.
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_alloc_starts_scan, clk, arst_n,
		req_valid && !req_stall && (req_action == ACT_ALLOC), state_q == ST_SCAN)
	`ASSERT_NEXT(a_scan_done_finishes, clk, arst_n,
		(state_q == ST_SCAN) && sts.scan_done, state_q == ST_FINISH)
	`ASSERT_NEXT(a_finish_returns_idle, clk, arst_n,
		(state_q == ST_FINISH) && sts.out_free, (state_q == ST_IDLE) && !req_stall)

endmodule

>>> rtl/core/fbfa_dp.sv
// Datapath of the block allocator: configuration registers, free-size table,
// scan compare, write-back and result register. Depends on fbfa_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbfa_dp
	import fbfa_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output rsp_t                  rsp,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_RW = $clog2(MAX_BLOCKS + 1);
	localparam int CNT_W  = (CNT_RW > NB_W) ? CNT_RW : NB_W;

	// Configuration registers.
	logic            fit_mode_q;
	logic [NB_W-1:0] num_blocks_q;

	// Free-size table and its valid bits; an entry never written reads as zero.
	logic [VAL_W-1:0] mem_q [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] vld_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;

	// Scan state.
	logic [VAL_W-1:0] req_q;
	logic             mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_q;
	logic             found_q;
	logic [VAL_W-1:0] best_q;
	logic [IDX_W-1:0] pick_q;

	logic             rd_pend_s1;
	logic             rd_live_s1;
	logic [VAL_W-1:0] rd_data_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             out_vld_q;
	rsp_t             out_q;

	logic [CNT_W-1:0] nb_ext;
	logic [CNT_W-1:0] cnt_sat;
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic [VAL_W-1:0] rd_val;
	logic             hit;
	logic             load_ok;
	logic [VAL_W-1:0] after;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= FIT_FIRST;
			num_blocks_q <= NUM_BLOCKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FIT_MODE:   fit_mode_q   <= cfg_data[0];
				REG_NUM_BLOCKS: num_blocks_q <= cfg_data[NB_W-1:0];
				default: ;
			endcase
		end
	end

	assign nb_ext  = CNT_W'(num_blocks_q);
	assign cnt_sat = (nb_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : nb_ext;
	assign issue   = cmd.scan && (scan_q < cnt_q);
	assign rd_addr = scan_q[IDX_W-1:0];
	assign rd_val  = rd_live_s1 ? rd_data_s1 : '0;

	// In first fit the first hit ends the scan; best fit keeps the smallest, and
	// a strict compare leaves the lower index in place on a tie.
	assign hit = cmd.scan && rd_pend_s1 && (rd_val >= req_q) &&
		(!found_q || ((mode_q == FIT_BEST) && (rd_val < best_q)));

	assign sts.scan_done = (found_q && (mode_q == FIT_FIRST)) ||
		(!(scan_q < cnt_q) && !rd_pend_s1);
	assign sts.out_free  = !out_vld_q || !rsp_stall;

	assign load_ok = CNT_W'(req.block_index) < CNT_W'(MAX_BLOCKS);
	assign after   = best_q - req_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pick_q;
		wr_data = after;
		if (cmd.load) begin
			wr_en   = load_ok;
			wr_addr = IDX_W'(req.block_index);
			wr_data = req.value;
		end else if (cmd.finish) begin
			wr_en = found_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem_q[rd_addr];
			rd_live_s1 <= vld_q[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else if (cmd.start) begin
			scan_q     <= '0;
			cnt_q      <= cnt_sat;
			found_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else if (cmd.scan) begin
			rd_pend_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= req.value;
			mode_q <= fit_mode_q;
		end
		if (hit) begin
			best_q <= rd_val;
			pick_q <= rd_idx_s1;
		end
		if (cmd.finish) begin
			out_q.granted      <= found_q;
			out_q.chosen_block <= found_q ? BIDX_W'(pick_q) : '0;
			out_q.free_before  <= found_q ? best_q : '0;
			out_q.free_after   <= found_q ? after : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	`ASSERT_PROP(a_fail_fields_zero, clk, arst_n,
		!(out_vld_q && !out_q.granted) ||
		((out_q.chosen_block == '0) && (out_q.free_before == '0) && (out_q.free_after == '0)))
	`ASSERT_PROP(a_grant_shrinks, clk, arst_n,
		!(out_vld_q && out_q.granted) || (out_q.free_after <= out_q.free_before))
	`ASSERT_PROP(a_scan_in_range, clk, arst_n, scan_q <= cnt_q)
	`ASSERT_PROP(a_best_fits, clk, arst_n, !found_q || (best_q >= req_q))

endmodule

>>> rtl/core/first_best_fit_block_allocator_unit.sv
// Top level of the first/best fit block allocator.
// Depends on fbfa_pkg, fbfa_ctrl and fbfa_dp.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one beat per item: a load beat writes a block's free
// size and returns nothing; an allocate beat scans the table and returns one
// rsp beat with the grant, the block index and the free size before and after.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The cfg channel (valid/ready, always ready) writes fit_mode at index 0 and
// num_blocks at index 1; write it only while no allocate is in flight.
// A load writes its table entry when it is accepted. An allocate scans up to
// count table entries before its result is registered, count being num_blocks
// capped at MAX_BLOCKS; the scan reads one table entry per cycle through the
// single read port, and in first fit it stops once the first block that fits
// has been found.
// The next item is accepted as soon as the result is registered, even while
// that result is stalled; a second finished result waits until the first
// has been taken. Reset clears the table to zero, sets first fit and a
// count of 16, and empties the result register.

module first_best_fit_block_allocator_unit
	import fbfa_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	fbfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.req_stall  (req_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	fbfa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
